FILE: src/multilevel_sjf_srtn_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent assertion helpers for the multilevel scheduler; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_SJF_SRTN_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_SJF_SRTN_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define MSS_ASSERT_SAME(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Condition a implies condition b in the following cycle.
`define MSS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define MSS_ASSERT_SAME(label, clk, rst_n, a, b, msg)
`define MSS_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

FILE: src/mss_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Codes, register indexes and the scan token shared by the scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none
package mss_pkg;

    // Item operations.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_IDLE = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_QUEUE_COUNT = 3'd0;
    localparam logic [2:0] CFG_SLICE0      = 3'd1;
    localparam logic [2:0] CFG_SLICE1      = 3'd2;
    localparam logic [2:0] CFG_SLICE2      = 3'd3;
    localparam logic [2:0] CFG_POLICY      = 3'd4;

    // Slot numbers carried on the chain are wide enough for the largest table.
    localparam int SLOT_IDX_W = 6;

    // Best candidate so far, handed from cell to cell during a scan.
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic                  forced;
        logic [15:0]           remaining;
        logic [SLOT_IDX_W-1:0] slot;
        logic [7:0]            id;
        logic [15:0]           arrival;
        logic [15:0]           burst;
    } token_t;

endpackage
`default_nettype wire

FILE: src/mss_cell.sv
// ----------------------------------------------------------------------------
// Scheduler table cell
// Holds one process slot and merges its own entry into the passing scan token.
// ----------------------------------------------------------------------------
`default_nettype none
module mss_cell
    import mss_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [SLOT_IDX_W-1:0] slot_index,
    input  wire logic                  wr_en,
    input  wire logic [SLOT_IDX_W-1:0] wr_slot,
    input  wire logic [7:0]            wr_id,
    input  wire logic [15:0]           wr_arrival,
    input  wire logic [15:0]           wr_burst,
    input  wire logic [1:0]            wr_queue,
    input  wire logic                  dec_en,
    input  wire logic [SLOT_IDX_W-1:0] dec_slot,
    input  wire logic                  force_en,
    input  wire logic [SLOT_IDX_W-1:0] force_slot,
    input  wire logic [1:0]            serve_queue,
    input  wire logic [TIME_BITS-1:0]  ticks,
    input  wire token_t                tok_in,
    output token_t                     tok_out
);

    localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

    logic        valid_reg;
    logic [7:0]  id_reg;
    logic [15:0] arrival_reg;
    logic [15:0] burst_reg;
    logic [15:0] remaining_reg;
    logic [1:0]  queue_reg;
    token_t      tok_reg;
    token_t      tok_next;
    logic        ready;
    logic        forced;
    logic        take;

    // A ready job belongs to the served queue, has arrived and still has work.
    assign ready = valid_reg && (queue_reg == serve_queue) &&
                   (CMP_W'(arrival_reg) <= CMP_W'(ticks)) && (remaining_reg != 16'd0);
    assign forced = force_en && (force_slot == slot_index);

    // A held job that is ready always wins; otherwise strictly shorter wins, so ties stay early.
    assign take = ready && (!tok_in.found || forced ||
                            (!tok_in.forced && (remaining_reg < tok_in.remaining)));

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && take)
        begin
            tok_next.found     = 1'b1;
            tok_next.forced    = forced;
            tok_next.remaining = remaining_reg;
            tok_next.slot      = slot_index;
            tok_next.id        = id_reg;
            tok_next.arrival   = arrival_reg;
            tok_next.burst     = burst_reg;
        end
    end

    // Token stage toward the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    // Slot occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_en && (wr_slot == slot_index))
        begin
            valid_reg <= 1'b1;
        end
    end

    // Slot contents; the remaining time counts down as the job runs.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_slot == slot_index))
        begin
            id_reg        <= wr_id;
            arrival_reg   <= wr_arrival;
            burst_reg     <= wr_burst;
            remaining_reg <= wr_burst;
            queue_reg     <= wr_queue;
        end
        else if (dec_en && (dec_slot == slot_index))
        begin
            remaining_reg <= remaining_reg - 16'd1;
        end
    end

endmodule
`default_nettype wire

FILE: src/multilevel_sjf_srtn_scheduler.sv
// ----------------------------------------------------------------------------
// Multilevel SJF/SRTN scheduler
// Process table in a chain of cells with a tick sequencer and queue rotation.
// ----------------------------------------------------------------------------
// An add transaction strobes its result on done in the cycle after acceptance.
// A tick transaction scans the cell chain once for each queue tried, and in
// each scan the candidate token walks the cells one per cycle; the number of
// queues tried runs from 1 to the number of queues in use. Every result is
// shown for exactly one cycle on done and must be taken then; busy stays high
// while a tick is being worked on.
`default_nettype none
`include "multilevel_sjf_srtn_scheduler_defines.svh"
module multilevel_sjf_srtn_scheduler
    import mss_pkg::*;
#(
    parameter int PROC_SLOTS  = 16,
    parameter int QUEUE_SLOTS = 3,
    parameter int TIME_BITS   = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        operation,
    input  wire logic [7:0]  process_id,
    input  wire logic [15:0] arrival_time,
    input  wire logic [15:0] burst_time,
    input  wire logic [1:0]  queue_index,
    output logic             done,
    output logic [1:0]       status,
    output logic             running_valid,
    output logic [7:0]       running_id,
    output logic [1:0]       running_queue,
    output logic             finished,
    output logic [15:0]      completion_time,
    output logic [15:0]      turnaround_time,
    output logic [15:0]      waiting_time,
    output logic [15:0]      time_now,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int IDX_W = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
    localparam int CNT_W = $clog2(PROC_SLOTS + 1);
    localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [1:0] QMAX = 2'(QUEUE_SLOTS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LAUNCH = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           qcount_reg;
    logic [15:0]          slice_reg [3];
    logic [2:0]           policy_reg;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [TIME_BITS-1:0] ticks_reg, ticks_next;
    logic [1:0]           serving_reg, serving_next;
    logic [15:0]          spent_reg, spent_next;
    logic [IDX_W-1:0]     held_reg, held_next;
    logic                 held_valid_reg, held_valid_next;
    logic [1:0]           tries_reg, tries_next;

    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic                 run_reg, run_next;
    logic [7:0]           run_id_reg, run_id_next;
    logic [1:0]           run_q_reg, run_q_next;
    logic                 fin_reg, fin_next;
    logic [15:0]          comp_reg, comp_next;
    logic [15:0]          turn_reg, turn_next;
    logic [15:0]          wait_reg, wait_next;

    token_t               chain [PROC_SLOTS+1];
    token_t               last;
    logic                 accept;
    logic                 wr_en;
    logic                 dec_en;
    logic                 force_en;
    logic [1:0]           nq;
    logic [1:0]           q_after;
    logic [15:0]          slice_cur;
    logic [TIME_BITS-1:0] ticks_inc;
    logic [CMP_W-1:0]     done_ext;
    logic [CMP_W-1:0]     arr_ext;
    logic [CMP_W-1:0]     burst_ext;
    logic [CMP_W-1:0]     turn_ext;
    logic [CMP_W-1:0]     wait_ext;
    logic [CMP_W-1:0]     now_ext;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign last      = chain[PROC_SLOTS];

    // Queues in use: zero counts as one, anything above the build limit is cut.
    always_comb
    begin
        nq = (qcount_reg == 2'd0) ? 2'd1 : qcount_reg;
        if (nq > QMAX)
        begin
            nq = QMAX;
        end
    end

    assign q_after   = (serving_reg + 2'd1 >= nq) ? 2'd0 : serving_reg + 2'd1;
    assign slice_cur = (slice_reg[serving_reg] == 16'd0) ? 16'd1 : slice_reg[serving_reg];
    assign ticks_inc = (ticks_reg == TIME_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign force_en  = held_valid_reg && !policy_reg[serving_reg];

    // Completion statistics for the picked job, floored at zero.
    assign done_ext  = CMP_W'(ticks_inc);
    assign arr_ext   = CMP_W'(last.arrival);
    assign burst_ext = CMP_W'(last.burst);
    assign turn_ext  = (done_ext >= arr_ext) ? done_ext - arr_ext : '0;
    assign wait_ext  = (turn_ext >= burst_ext) ? turn_ext - burst_ext : '0;
    assign now_ext   = CMP_W'(ticks_reg);

    // Scan token injected at the head of the chain.
    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = (state_reg == S_LAUNCH);
    end

    assign wr_en  = accept && (operation == OP_ADD) && (used_reg < CNT_W'(PROC_SLOTS));
    assign dec_en = (state_reg == S_SCAN) && last.valid && last.found;

    // Row of table cells.
    for (genvar i = 0; i < PROC_SLOTS; i++)
    begin : g_cell
        mss_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .slot_index  (SLOT_IDX_W'(i)),
            .wr_en       (wr_en),
            .wr_slot     (SLOT_IDX_W'(used_reg)),
            .wr_id       (process_id),
            .wr_arrival  (arrival_time),
            .wr_burst    (burst_time),
            .wr_queue    (queue_index),
            .dec_en      (dec_en),
            .dec_slot    (last.slot),
            .force_en    (force_en),
            .force_slot  (SLOT_IDX_W'(held_reg)),
            .serve_queue (serving_reg),
            .ticks       (ticks_reg),
            .tok_in      (chain[i]),
            .tok_out     (chain[i+1])
        );
    end

    // Sequencer for add and tick transactions.
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        ticks_next      = ticks_reg;
        serving_next    = serving_reg;
        spent_next      = spent_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        tries_next      = tries_reg;
        done_next       = 1'b0;
        status_next     = ST_OK;
        run_next        = 1'b0;
        run_id_next     = 8'd0;
        run_q_next      = 2'd0;
        fin_next        = 1'b0;
        comp_next       = 16'd0;
        turn_next       = 16'd0;
        wait_next       = 16'd0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_ADD)
                    begin
                        done_next = 1'b1;
                        if (wr_en)
                        begin
                            used_next = used_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    else
                    begin
                        tries_next = 2'd0;
                        if (serving_reg >= nq)
                        begin
                            serving_next    = 2'd0;
                            spent_next      = 16'd0;
                            held_valid_next = 1'b0;
                        end
                        state_next = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (last.valid)
                begin
                    if (last.found)
                    begin
                        // Run the picked job for one tick.
                        done_next       = 1'b1;
                        run_next        = 1'b1;
                        run_id_next     = last.id;
                        run_q_next      = serving_reg;
                        ticks_next      = ticks_inc;
                        held_next       = last.slot[IDX_W-1:0];
                        held_valid_next = 1'b1;
                        spent_next      = spent_reg + 16'd1;
                        if (last.remaining == 16'd1)
                        begin
                            fin_next        = 1'b1;
                            comp_next       = done_ext[15:0];
                            turn_next       = turn_ext[15:0];
                            wait_next       = wait_ext[15:0];
                            held_valid_next = 1'b0;
                        end
                        if (spent_reg + 16'd1 >= slice_cur)
                        begin
                            serving_next    = q_after;
                            spent_next      = 16'd0;
                            held_valid_next = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Nothing ready here: rotate to the next queue.
                        serving_next    = q_after;
                        spent_next      = 16'd0;
                        held_valid_next = 1'b0;
                        tries_next      = tries_reg + 2'd1;
                        if (tries_reg + 2'd1 >= nq)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_IDLE;
                            ticks_next  = ticks_inc;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_LAUNCH;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            ticks_reg      <= '0;
            serving_reg    <= 2'd0;
            spent_reg      <= 16'd0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            tries_reg      <= 2'd0;
            done_reg       <= 1'b0;
            status_reg     <= ST_OK;
            run_reg        <= 1'b0;
            run_id_reg     <= 8'd0;
            run_q_reg      <= 2'd0;
            fin_reg        <= 1'b0;
            comp_reg       <= 16'd0;
            turn_reg       <= 16'd0;
            wait_reg       <= 16'd0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            ticks_reg      <= ticks_next;
            serving_reg    <= serving_next;
            spent_reg      <= spent_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            tries_reg      <= tries_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            run_reg        <= run_next;
            run_id_reg     <= run_id_next;
            run_q_reg      <= run_q_next;
            fin_reg        <= fin_next;
            comp_reg       <= comp_next;
            turn_reg       <= turn_next;
            wait_reg       <= wait_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcount_reg   <= 2'd1;
            slice_reg[0] <= 16'd4;
            slice_reg[1] <= 16'd4;
            slice_reg[2] <= 16'd4;
            policy_reg   <= 3'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_QUEUE_COUNT: qcount_reg   <= cfg_data[1:0];
                CFG_SLICE0:      slice_reg[0] <= cfg_data;
                CFG_SLICE1:      slice_reg[1] <= cfg_data;
                CFG_SLICE2:      slice_reg[2] <= cfg_data;
                CFG_POLICY:      policy_reg   <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign running_valid   = run_reg;
    assign running_id      = run_id_reg;
    assign running_queue   = run_q_reg;
    assign finished        = fin_reg;
    assign completion_time = comp_reg;
    assign turnaround_time = turn_reg;
    assign waiting_time    = wait_reg;
    assign time_now        = now_ext[15:0];

    // Checks on the sequencer and table.
    `MSS_ASSERT_SAME(a_idle_no_run, clk, rst_n, done && (status == ST_IDLE), !running_valid, "idle tick reported a running job")
    `MSS_ASSERT_SAME(a_finish_runs, clk, rst_n, finished, running_valid && done, "finish without a running job")
    `MSS_ASSERT_NEXT(a_tick_busy, clk, rst_n, accept && (operation == OP_TICK), busy && !done, "tick did not start a scan")
    `MSS_ASSERT_SAME(a_used_bound, clk, rst_n, 1'b1, used_reg <= CNT_W'(PROC_SLOTS), "table count overflow")

endmodule
`default_nettype wire
